>>> design/fmst_pkg.sv
package fmst_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int LVL_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int CNT_W    = VAL_W + LVL_W;
    localparam int ELEM_W   = VAL_W + LVL_W;

    localparam logic [LVL_W-1:0] EMPTY_MARK = LVL_W'(CAPACITY);

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [1:0] ST_PUSH_DONE = 2'd0;
    localparam logic [1:0] ST_POP_DONE  = 2'd1;
    localparam logic [1:0] ST_POP_EMPTY = 2'd2;
    localparam logic [1:0] ST_PUSH_FULL = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PHEAD,
        S_PELEM,
        S_SCAN,
        S_APPLY,
        S_PUSH2,
        S_DONE
    } seq_state_t;

endpackage

>>> design/fmst_ram.sv
module fmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/max_frequency_stack_top.sv
// Maximum-frequency stack of up to CAPACITY 32-bit values. A push raises the
// value's count and stacks it on that count's level; a pop returns the newest
// value of the highest level. Each request returns one result. A request is
// handled one at a time: a push or pop scans the count table memory one entry
// per cycle until the value is found, plus steps of accept, level and element
// memory access and result hand-off. Pop on empty and push when full skip the
// scan and memory access and go straight to the result hand-off.
module max_frequency_stack_top
    import fmst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [0:0]  s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] popped_value, [38:32] top_level, zero pad
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    seq_state_t state_reg, state_next;

    logic              act_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [LVL_W-1:0]  held_count_reg;
    logic [LVL_W-1:0]  max_level_reg;
    logic [LVL_W-1:0]  free_head_reg;
    logic [CAPACITY:0] lh_valid_reg;
    logic [CAPACITY-1:0] link_valid_reg;
    logic [CAPACITY-1:0] cnt_valid_reg;
    logic [LVL_W-1:0]  idx_reg;
    logic [SLOT_W-1:0] prev_reg;
    logic              pv_reg;
    logic [SLOT_W-1:0] ff_reg;
    logic              ff_set_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] ent_reg;
    logic [LVL_W-1:0]  cnt_old_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [VAL_W-1:0]  res_value_reg;
    logic [1:0]        res_status_reg;
    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic [1:0]        out_status_reg;
    logic [LVL_W-1:0]  out_level_reg;

    // memory ports
    logic              cnt_we;
    logic [SLOT_W-1:0] cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
    logic              lh_we;
    logic [LVL_W-1:0]  lh_waddr, lh_raddr;
    logic [LVL_W-1:0]  lh_wdata, lh_rdata;
    logic              el_we;
    logic [SLOT_W-1:0] el_waddr, el_raddr;
    logic [ELEM_W-1:0] el_wdata, el_rdata;
    logic              fl_we;
    logic [SLOT_W-1:0] fl_waddr, fl_raddr;
    logic [LVL_W-1:0]  fl_wdata, fl_rdata;

    logic              in_fire;
    logic              out_free;
    logic              hit_now;
    logic              scan_end;
    logic [LVL_W-1:0]  new_cnt;
    logic [LVL_W-1:0]  below;
    logic [LVL_W-1:0]  next_free;

    fmst_ram #(.WIDTH(CNT_W), .DEPTH(CAPACITY)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );
    fmst_ram #(.WIDTH(LVL_W), .DEPTH(CAPACITY + 1)) u_lh_ram (
        .clk(clk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
        .raddr(lh_raddr), .rdata(lh_rdata)
    );
    fmst_ram #(.WIDTH(ELEM_W), .DEPTH(CAPACITY)) u_elem_ram (
        .clk(clk), .we(el_we), .waddr(el_waddr), .wdata(el_wdata),
        .raddr(el_raddr), .rdata(el_rdata)
    );
    fmst_ram #(.WIDTH(LVL_W), .DEPTH(CAPACITY)) u_link_ram (
        .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
        .raddr(fl_raddr), .rdata(fl_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign hit_now  = pv_reg && cnt_valid_reg[prev_reg]
                      && (cnt_rdata[CNT_W-1:LVL_W] == val_reg);
    assign scan_end = pv_reg && (prev_reg == SLOT_W'(CAPACITY - 1));
    assign new_cnt  = cnt_old_reg + LVL_W'(1);
    assign below    = lh_valid_reg[lvl_reg] ? lh_rdata : EMPTY_MARK;
    assign next_free = link_valid_reg[slot_reg] ? fl_rdata
                                                : LVL_W'({1'b0, slot_reg} + 1'b1);

    always_comb
    begin
        state_next = state_reg;
        cnt_we     = 1'b0;
        cnt_waddr  = ent_reg;
        cnt_wdata  = {val_reg, new_cnt};
        cnt_raddr  = idx_reg[SLOT_W-1:0];
        lh_we      = 1'b0;
        lh_waddr   = lvl_reg;
        lh_wdata   = LVL_W'(slot_reg);
        lh_raddr   = max_level_reg;
        el_we      = 1'b0;
        el_waddr   = slot_reg;
        el_wdata   = {val_reg, below};
        el_raddr   = lh_rdata[SLOT_W-1:0];
        fl_we      = 1'b0;
        fl_waddr   = slot_reg;
        fl_wdata   = free_head_reg;
        fl_raddr   = free_head_reg[SLOT_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser[0] == ACT_POP)
                    begin
                        state_next = (held_count_reg == '0) ? S_DONE : S_PHEAD;
                    end
                    else
                    begin
                        state_next = (held_count_reg >= LVL_W'(CAPACITY)) ? S_DONE : S_SCAN;
                    end
                end
            end
            S_PHEAD:
            begin
                state_next = S_PELEM;
            end
            S_PELEM:
            begin
                lh_we      = 1'b1;
                lh_waddr   = max_level_reg;
                lh_wdata   = el_rdata[LVL_W-1:0];
                fl_we      = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (hit_now || scan_end)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (act_reg == ACT_PUSH)
                begin
                    cnt_we     = 1'b1;
                    lh_raddr   = new_cnt;
                    state_next = S_PUSH2;
                end
                else
                begin
                    // drop one occurrence; the entry is freed through its valid bit at zero
                    cnt_we     = hit_reg && (cnt_old_reg > LVL_W'(1));
                    cnt_wdata  = {val_reg, cnt_old_reg - LVL_W'(1)};
                    state_next = S_DONE;
                end
            end
            S_PUSH2:
            begin
                el_we      = 1'b1;
                lh_we      = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
            max_level_reg  <= '0;
            free_head_reg  <= '0;
            lh_valid_reg   <= '0;
            link_valid_reg <= '0;
            cnt_valid_reg  <= '0;
            pv_reg         <= 1'b0;
            ff_set_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready && !((state_reg == S_DONE) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg    <= '0;
                    pv_reg     <= 1'b0;
                    ff_set_reg <= 1'b0;
                    if (in_fire)
                    begin
                        act_reg       <= s_axis_tuser[0];
                        val_reg       <= s_axis_tdata;
                        res_value_reg <= '0;
                        if (s_axis_tuser[0] == ACT_POP)
                        begin
                            res_status_reg <= ST_POP_EMPTY;
                        end
                        else
                        begin
                            res_status_reg <= ST_PUSH_FULL;
                        end
                    end
                end
                S_PHEAD:
                begin
                    slot_reg <= lh_rdata[SLOT_W-1:0];
                end
                S_PELEM:
                begin
                    val_reg                  <= el_rdata[ELEM_W-1:LVL_W];
                    lh_valid_reg[max_level_reg] <= 1'b1;
                    link_valid_reg[slot_reg] <= 1'b1;
                    free_head_reg            <= LVL_W'(slot_reg);
                    held_count_reg           <= held_count_reg - LVL_W'(1);
                    if (el_rdata[LVL_W-1:0] == EMPTY_MARK)
                    begin
                        max_level_reg <= max_level_reg - LVL_W'(1);
                    end
                end
                S_SCAN:
                begin
                    // read one entry a cycle, compare the one read last cycle
                    if (idx_reg < LVL_W'(CAPACITY))
                    begin
                        idx_reg  <= idx_reg + LVL_W'(1);
                        prev_reg <= idx_reg[SLOT_W-1:0];
                        pv_reg   <= 1'b1;
                    end
                    if (pv_reg && !cnt_valid_reg[prev_reg] && !ff_set_reg)
                    begin
                        ff_reg     <= prev_reg;
                        ff_set_reg <= 1'b1;
                    end
                    if (hit_now)
                    begin
                        hit_reg     <= 1'b1;
                        ent_reg     <= prev_reg;
                        cnt_old_reg <= cnt_rdata[LVL_W-1:0];
                    end
                    else if (scan_end)
                    begin
                        hit_reg     <= 1'b0;
                        ent_reg     <= ff_set_reg ? ff_reg : prev_reg;
                        cnt_old_reg <= '0;
                    end
                end
                S_APPLY:
                begin
                    if (act_reg == ACT_PUSH)
                    begin
                        cnt_valid_reg[ent_reg] <= 1'b1;
                        lvl_reg  <= new_cnt;
                        slot_reg <= free_head_reg[SLOT_W-1:0];
                    end
                    else
                    begin
                        if (hit_reg && (cnt_old_reg <= LVL_W'(1)))
                        begin
                            cnt_valid_reg[ent_reg] <= 1'b0;
                        end
                        res_value_reg  <= val_reg;
                        res_status_reg <= ST_POP_DONE;
                    end
                end
                S_PUSH2:
                begin
                    lh_valid_reg[lvl_reg] <= 1'b1;
                    free_head_reg  <= next_free;
                    held_count_reg <= held_count_reg + LVL_W'(1);
                    if (lvl_reg > max_level_reg)
                    begin
                        max_level_reg <= lvl_reg;
                    end
                    res_status_reg <= ST_PUSH_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_value_reg  <= res_value_reg;
                        out_status_reg <= res_status_reg;
                        out_level_reg  <= max_level_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_level_reg, out_value_reg};
    assign m_axis_tuser  = out_status_reg;

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= LVL_W'(CAPACITY))
        else $error("held count beyond capacity");

    a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
        (held_count_reg == '0) |-> (max_level_reg == '0))
        else $error("empty stack with nonzero top level");

    a_pop_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_POP_EMPTY)) |-> (out_level_reg == '0))
        else $error("pop on empty reports a level");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        max_level_reg <= held_count_reg)
        else $error("top level exceeds element count");

endmodule
